// File: sv/pcg_pkg.sv
// Shared types, constants and the output permutation of the PCG32 generator.
`timescale 1ns / 1ps

package pcg_pkg;

   localparam int unsigned KIND_WIDTH      = 2;
   localparam int unsigned SEED_WIDTH      = 64;
   localparam int unsigned STREAM_WIDTH    = 63;
   localparam int unsigned VALUE_WIDTH     = 53;
   localparam int unsigned STATE_WIDTH     = 64;
   localparam int unsigned WORD_WIDTH      = 32;
   localparam int unsigned CMD_QUEUE_DEPTH = 2;

   localparam logic [STATE_WIDTH-1:0] PCG_MULTIPLIER = 64'd6364136223846793005;
   localparam int unsigned XSH_SHIFT = 18;
   localparam int unsigned XSH_TAKE  = 27;
   localparam int unsigned ROT_LSB   = 59;

   typedef enum logic [KIND_WIDTH-1:0] {
      KIND_SEED   = 2'd0,
      KIND_DRAW32 = 2'd1,
      KIND_DRAW53 = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type                  kind;
      logic [SEED_WIDTH-1:0]     seed_value;
      logic [STREAM_WIDTH-1:0]   stream_select;
   } cmd_type;

   // XSH-RR output: xorshift, keep 32 bits, rotate right by the top five state bits.
   function automatic logic [WORD_WIDTH-1:0] pcg_permute(input logic [STATE_WIDTH-1:0] prior);
      logic [STATE_WIDTH-1:0]  mixed_wide;
      logic [WORD_WIDTH-1:0]   mixed;
      logic [4:0]              turn;
      logic [2*WORD_WIDTH-1:0] doubled;
      mixed_wide = (prior >> XSH_SHIFT) ^ prior;
      mixed      = mixed_wide[XSH_TAKE +: WORD_WIDTH];
      turn       = prior[ROT_LSB +: 5];
      doubled    = {mixed, mixed} >> turn;
      return doubled[WORD_WIDTH-1:0];
   endfunction

endpackage

// File: sv/pcg_req_if.sv
// Request channel interface: valid/ready handshake carrying one generator command.
`timescale 1ns / 1ps

interface pcg_req_if;
   import pcg_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [KIND_WIDTH-1:0]   kind;
   logic [SEED_WIDTH-1:0]   seed_value;
   logic [STREAM_WIDTH-1:0] stream_select;

   modport source (output valid, output kind, output seed_value, output stream_select,
                   input ready);
   modport sink   (input valid, input kind, input seed_value, input stream_select,
                   output ready);
endinterface

// File: sv/pcg_rsp_if.sv
// Response channel interface: valid/ready handshake carrying one random value.
`timescale 1ns / 1ps

interface pcg_rsp_if;
   import pcg_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [VALUE_WIDTH-1:0] random_value;

   modport source (output valid, output random_value, input ready);
   modport sink   (input valid, input random_value, output ready);
endinterface

// File: sv/pcg32_random_generator_top.sv
// PCG32 (XSH-RR, 64-bit state) random generator top level.
//
// Requests arrive on req_chan as beats of kind, seed_value and stream_select.
// A seed beat restarts the generator on a new stream and gives no response;
// a draw32 beat returns one 32-bit word; a draw53 beat returns a 53-bit
// fraction numerator built from two words. Unused kind codes are accepted
// and dropped. Results leave on rsp_chan as random_value beats.
// The front end places commands in a two-entry queue, so requests are taken
// while the core is busy or a response waits. Each state advance runs
// through one split 64-bit multiply in the phases MUL1 and MUL2, after
// the command is taken from the queue in IDLE; a seed or draw32 advances
// the state once, a draw53 twice. If the receiver stalls, the finished
// response stays in the output register; the core finishes its next
// draw command and waits with that result. Synchronous reset empties
// the queue, drops any pending response and returns the generator to
// state 0 with increment 1.
`timescale 1ns / 1ps

module pcg32_random_generator_top #(
   parameter int unsigned QUEUE_DEPTH = pcg_pkg::CMD_QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   pcg_req_if.sink   req_chan,
   pcg_rsp_if.source rsp_chan
);
   import pcg_pkg::*;

   logic    push;
   cmd_type push_data;
   logic    queue_full;
   logic    pop;
   cmd_type pop_data;
   logic    queue_empty;

   pcg_front u_front (
      .req_chan   (req_chan),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data)
   );

   pcg_cmd_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (queue_empty)
   );

   pcg_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .pop_data    (pop_data),
      .pop         (pop),
      .rsp_chan    (rsp_chan)
   );

endmodule

// File: sv/pcg_front.sv
// Front end: takes request beats, decodes the kind and pushes real commands to the queue.
`timescale 1ns / 1ps

module pcg_front (
   pcg_req_if.sink         req_chan,
   input  logic            queue_full,
   output logic            push,
   output pcg_pkg::cmd_type push_data
);
   import pcg_pkg::*;

   logic known_kind;

   assign req_chan.ready = !queue_full;

   always_comb begin
      known_kind = 1'b1;
      push_data.kind = KIND_DRAW32;
      unique case (req_chan.kind)
         KIND_SEED:   push_data.kind = KIND_SEED;
         KIND_DRAW32: push_data.kind = KIND_DRAW32;
         KIND_DRAW53: push_data.kind = KIND_DRAW53;
         default:     known_kind = 1'b0;
      endcase
      push_data.seed_value    = req_chan.seed_value;
      push_data.stream_select = req_chan.stream_select;
   end

   // The unused kind is taken off the channel but never reaches the back end.
   assign push = req_chan.valid && req_chan.ready && known_kind;

endmodule

// File: sv/pcg_cmd_fifo.sv
// Short command queue between the front end and the generator core.
`timescale 1ns / 1ps

module pcg_cmd_fifo #(
   parameter int unsigned DEPTH = pcg_pkg::CMD_QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  pcg_pkg::cmd_type push_data,
   output logic             full,
   input  logic             pop,
   output pcg_pkg::cmd_type pop_data,
   output logic             empty
);
   import pcg_pkg::*;

   localparam int unsigned PTR_WIDTH   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned COUNT_WIDTH = $clog2(DEPTH + 1);

   cmd_type                entry_ff [DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;

   function automatic logic [PTR_WIDTH-1:0] ptr_step(input logic [PTR_WIDTH-1:0] ptr);
      return (ptr == PTR_WIDTH'(DEPTH - 1)) ? '0 : ptr + 1'b1;
   endfunction

   assign full     = (count_ff == COUNT_WIDTH'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_step(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_step(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      !(push && full && !pop)) else $error("command queue overrun");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty)) else $error("command queue underrun");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_WIDTH'(DEPTH)) else $error("command queue count out of range");
`endif

endmodule

// File: sv/pcg_back.sv
// Generator core: holds the LCG state, runs the split 64-bit multiply and builds results.
`timescale 1ns / 1ps

module pcg_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             queue_empty,
   input  pcg_pkg::cmd_type pop_data,
   output logic             pop,
   pcg_rsp_if.source        rsp_chan
);
   import pcg_pkg::*;

   localparam int unsigned HALF = STATE_WIDTH / 2;
   localparam logic [HALF-1:0] MULT_LO = PCG_MULTIPLIER[HALF-1:0];
   localparam logic [HALF-1:0] MULT_HI = PCG_MULTIPLIER[STATE_WIDTH-1:HALF];

   typedef enum logic [1:0] {
      S_IDLE,
      S_MUL1,
      S_MUL2,
      S_HOLD
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [STATE_WIDTH-1:0] lcg_state_ff, lcg_state_in;
   logic [STATE_WIDTH-1:0] lcg_increment_ff, lcg_increment_in;
   logic [1:0]             adv_left_ff, adv_left_in;
   logic                   emit_ff, emit_in;
   logic                   wide_ff, wide_in;
   logic [STATE_WIDTH-1:0] prod_lo_ff, prod_lo_in;
   logic [HALF-1:0]        cross_ff, cross_in;
   logic [WORD_WIDTH-1:0]  word_ff, word_in;
   logic [26:0]            upper_ff, upper_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VALUE_WIDTH-1:0] rsp_value_ff, rsp_value_in;

   logic                   out_free;
   logic                   out_load;
   logic [STREAM_WIDTH:0]  new_increment;
   logic [WORD_WIDTH-1:0]  permuted;
   logic [STATE_WIDTH-1:0] lo_product;
   logic [HALF-1:0]        hi_cross;
   logic [HALF-1:0]        lo_cross;
   logic [STATE_WIDTH-1:0] next_state;
   logic [VALUE_WIDTH-1:0] result;

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.random_value = rsp_value_ff;

   assign out_free      = !rsp_valid_ff || rsp_chan.ready;
   assign new_increment = {pop_data.stream_select, 1'b1};
   assign permuted      = pcg_permute(lcg_state_ff);

   // The 64x64 product modulo 2^64 is split over MUL1 and MUL2: the full low
   // partial product and one truncated cross term in MUL1, the other cross
   // term and the final sum in MUL2.
   assign lo_product = STATE_WIDTH'(lcg_state_ff[HALF-1:0]) * STATE_WIDTH'(MULT_LO);
   assign hi_cross   = HALF'(lcg_state_ff[STATE_WIDTH-1:HALF] * MULT_LO);
   assign lo_cross   = HALF'(lcg_state_ff[HALF-1:0] * MULT_HI);
   assign next_state = prod_lo_ff + {cross_ff + lo_cross, {HALF{1'b0}}} + lcg_increment_ff;

   assign result = wide_ff ? {upper_ff, word_ff[WORD_WIDTH-1:6]} : VALUE_WIDTH'(word_ff);

   always_comb begin
      phase_in         = phase_ff;
      lcg_state_in     = lcg_state_ff;
      lcg_increment_in = lcg_increment_ff;
      adv_left_in      = adv_left_ff;
      emit_in          = emit_ff;
      wide_in          = wide_ff;
      prod_lo_in       = prod_lo_ff;
      cross_in         = cross_ff;
      word_in          = word_ff;
      upper_in         = upper_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_value_in     = rsp_value_ff;
      pop              = 1'b0;
      out_load         = 1'b0;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (phase_ff)
         S_IDLE: begin
            if (!queue_empty) begin
               pop      = 1'b1;
               phase_in = S_MUL1;
               unique case (pop_data.kind)
                  KIND_SEED: begin
                     // Clearing the state and advancing once leaves just the increment.
                     lcg_increment_in = new_increment;
                     lcg_state_in     = new_increment + pop_data.seed_value;
                     adv_left_in      = 2'd1;
                     emit_in          = 1'b0;
                     wide_in          = 1'b0;
                  end
                  KIND_DRAW53: begin
                     adv_left_in = 2'd2;
                     emit_in     = 1'b1;
                     wide_in     = 1'b1;
                  end
                  default: begin
                     adv_left_in = 2'd1;
                     emit_in     = 1'b1;
                     wide_in     = 1'b0;
                  end
               endcase
            end
         end
         S_MUL1: begin
            prod_lo_in = lo_product;
            cross_in   = hi_cross;
            word_in    = permuted;
            if (adv_left_ff == 2'd2) begin
               upper_in = permuted[WORD_WIDTH-1:5];
            end
            phase_in = S_MUL2;
         end
         S_MUL2: begin
            lcg_state_in = next_state;
            adv_left_in  = adv_left_ff - 1'b1;
            if (adv_left_ff != 2'd1) begin
               phase_in = S_MUL1;
            end else if (!emit_ff) begin
               phase_in = S_IDLE;
            end else if (out_free) begin
               out_load = 1'b1;
               phase_in = S_IDLE;
            end else begin
               phase_in = S_HOLD;
            end
         end
         S_HOLD: begin
            if (out_free) begin
               out_load = 1'b1;
               phase_in = S_IDLE;
            end
         end
         default: phase_in = S_IDLE;
      endcase

      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= S_IDLE;
         lcg_state_ff     <= '0;
         lcg_increment_ff <= STATE_WIDTH'(1);
         adv_left_ff      <= '0;
         emit_ff          <= 1'b0;
         wide_ff          <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         phase_ff         <= phase_in;
         lcg_state_ff     <= lcg_state_in;
         lcg_increment_ff <= lcg_increment_in;
         adv_left_ff      <= adv_left_in;
         emit_ff          <= emit_in;
         wide_ff          <= wide_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      prod_lo_ff   <= prod_lo_in;
      cross_ff     <= cross_in;
      word_ff      <= word_in;
      upper_ff     <= upper_in;
      rsp_value_ff <= rsp_value_in;
   end

`ifndef SYNTHESIS
   a_increment_odd: assert property (@(posedge clock) disable iff (reset)
      lcg_increment_ff[0]) else $error("LCG increment became even");

   a_mul_has_work: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == S_MUL1) |-> (adv_left_ff == 2'd1 || adv_left_ff == 2'd2))
      else $error("multiply phase entered with no advance pending");

   a_hold_only_when_blocked: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == S_HOLD) |-> (emit_ff && rsp_valid_ff))
      else $error("result held without a pending beat");

   a_pop_starts_multiply: assert property (@(posedge clock) disable iff (reset)
      pop |=> (phase_ff == S_MUL1)) else $error("command popped but core did not start");
`endif

endmodule
